FILE: rtl/core/http_chunked_body_decoder_core_defines.svh
// Assertion macros shared by the checkers.
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH

// Condition holds on every clock outside reset.
`define CHBD_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define CHBD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CHBD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/chbd_pkg.sv
package chbd_pkg;

   localparam logic [1:0] OP_BYTE = 2'd0;
   localparam logic [1:0] OP_END  = 2'd1;
   localparam logic [1:0] OP_NEW  = 2'd2;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_BAD   = 2'd2;
   localparam logic [1:0] KIND_EARLY = 2'd3;

   localparam logic [2:0] PH_DIGITS = 3'd0;
   localparam logic [2:0] PH_EXT    = 3'd1;
   localparam logic [2:0] PH_LF     = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_TRAIL1 = 3'd4;
   localparam logic [2:0] PH_TRAIL2 = 3'd5;
   localparam logic [2:0] PH_DONE   = 3'd6;

   localparam logic [3:0] MAX_HEX_DIGITS = 4'd8;

   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [7:0] data;
   } step_result_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] b);
      hex_digit_type r;
      r.valid = 1'b1;
      r.value = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r.value = 4'(b - 8'h37);
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/chbd_frame.sv
module chbd_frame
   import chbd_pkg::*;
#(
   parameter logic [3:0] MAX_DIGITS = MAX_HEX_DIGITS
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  logic            chunked_enable,
   input  logic [1:0]      op,
   input  logic [7:0]      in_byte,
   output step_result_type result
);

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [31:0] left_ff, left_in;

   hex_digit_type hex;
   logic [3:0]    cnt_inc;
   logic [31:0]   left_dec;

   assign hex      = hex_decode(in_byte);
   assign cnt_inc  = cnt_ff + 4'd1;
   assign left_dec = left_ff - 32'd1;

   always_comb begin
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      left_in      = left_ff;
      result.valid = 1'b0;
      result.kind  = KIND_DATA;
      result.data  = 8'd0;
      case (op)
         OP_NEW: begin
            phase_in = PH_DIGITS;
            acc_in   = 32'd0;
            cnt_in   = 4'd0;
            left_in  = 32'd0;
         end
         OP_END: begin
            if (phase_ff != PH_DONE) begin
               phase_in     = PH_DONE;
               result.valid = 1'b1;
               result.kind  = chunked_enable ? KIND_EARLY : KIND_END;
            end
         end
         OP_BYTE: begin
            if (phase_ff != PH_DONE) begin
               if (!chunked_enable) begin
                  result.valid = 1'b1;
                  result.data  = in_byte;
               end else begin
                  case (phase_ff)
                     PH_DIGITS: begin
                        if (in_byte == CHAR_CR) begin
                           phase_in = PH_LF;
                        end else if (in_byte == CHAR_SEMI) begin
                           phase_in = PH_EXT;
                        end else if (!hex.valid) begin
                           phase_in     = PH_DONE;
                           result.valid = 1'b1;
                           result.kind  = KIND_BAD;
                        end else begin
                           acc_in = {acc_ff[27:0], hex.value};
                           cnt_in = cnt_inc;
                           if (cnt_inc > MAX_DIGITS) begin
                              phase_in     = PH_DONE;
                              result.valid = 1'b1;
                              result.kind  = KIND_BAD;
                           end
                        end
                     end
                     PH_EXT: begin
                        if (in_byte == CHAR_CR) begin
                           phase_in = PH_LF;
                        end
                     end
                     PH_LF: begin
                        if (cnt_ff == 4'd0) begin
                           phase_in     = PH_DONE;
                           result.valid = 1'b1;
                           result.kind  = KIND_BAD;
                        end else if (acc_ff == 32'd0 || acc_ff[31]) begin
                           phase_in     = PH_DONE;
                           result.valid = 1'b1;
                           result.kind  = KIND_END;
                        end else begin
                           left_in  = acc_ff;
                           phase_in = PH_DATA;
                        end
                     end
                     PH_DATA: begin
                        left_in      = left_dec;
                        result.valid = 1'b1;
                        result.data  = in_byte;
                        if (left_dec == 32'd0) begin
                           phase_in = PH_TRAIL1;
                        end
                     end
                     PH_TRAIL1: begin
                        phase_in = PH_TRAIL2;
                     end
                     PH_TRAIL2: begin
                        phase_in = PH_DIGITS;
                        acc_in   = 32'd0;
                        cnt_in   = 4'd0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DIGITS;
         acc_ff   <= 32'd0;
         cnt_ff   <= 4'd0;
         left_ff  <= 32'd0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         left_ff  <= left_in;
      end
   end

endmodule

FILE: rtl/core/http_chunked_body_decoder_core.sv
// Channel   Direction  Transaction
// req_      in         op (byte / stream end / new body) and raw byte
// rsp_      out        kind (data / end / malformed / early end) and byte
// csr_      in         chunked_enable write
//
// One transaction per cycle sustained while rsp_ready is high; a result, where the request
// yields one, goes through the input register, then the framing step into the result register.
// Synchronous reset clears the framing state, both stages and chunked_enable.
// With rsp_ready low the result holds and one more request is held in the
// input register; req_ready drops only when both stages are full and rsp_ready is low.
module http_chunked_body_decoder_core
   import chbd_pkg::*;
#(
   parameter logic [3:0] MAX_DIGITS = MAX_HEX_DIGITS
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_chunked_enable
);

   logic       in_valid_ff, in_valid_in;
   logic [1:0] op_ff;
   logic [7:0] byte_ff;
   logic       out_valid_ff, out_valid_in;
   logic [1:0] kind_ff;
   logic [7:0] data_ff;
   logic       enable_ff;

   logic            out_free;
   logic            advance;
   step_result_type result;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = out_free ? (advance && result.valid) : out_valid_ff;

   chbd_frame #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_frame (
      .clock          (clock),
      .reset          (reset),
      .step_en        (advance),
      .chunked_enable (enable_ff),
      .op             (op_ff),
      .in_byte        (byte_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         enable_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid) begin
            enable_ff <= csr_chunked_enable;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff   <= req_op;
         byte_ff <= req_in_byte;
      end
      if (advance && result.valid) begin
         kind_ff <= result.kind;
         data_ff <= result.data;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_kind = kind_ff;
   assign rsp_out_byte = data_ff;

endmodule

FILE: rtl/core/chbd_checker.sv
`include "http_chunked_body_decoder_core_defines.svh"

module chbd_checker
   import chbd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_out_kind,
   input logic [7:0] rsp_out_byte
);

   `CHBD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_kind) && $stable(rsp_out_byte), "rsp transaction changed while stalled")
   `CHBD_ASSERT_ALWAYS(a_byte_zero, !rsp_valid || rsp_out_kind == KIND_DATA || rsp_out_byte == 8'd0, "non-data result carries a byte")
   `CHBD_ASSERT_NOW(a_ready_when_empty, !rsp_valid, req_ready, "req stalled with empty result stage")
   `CHBD_ASSERT_NOW(a_idle_after_reset, $fell(reset), !rsp_valid, "result valid right after reset")

endmodule

bind http_chunked_body_decoder_core chbd_checker u_chbd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_kind (rsp_out_kind),
   .rsp_out_byte (rsp_out_byte)
);
